[hw/rtl/checked_number_format_convert_core_assert.svh]
// assertion macros for the number format converter
`ifndef CHECKED_NUMBER_FORMAT_CONVERT_CORE_ASSERT_SVH
`define CHECKED_NUMBER_FORMAT_CONVERT_CORE_ASSERT_SVH

// property must hold on every clock edge outside reset
`define CNFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CNFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cnfc_pkg.sv]
// ----------------------------------------------------------------------------
// cnfc_pkg
// types and codes shared by the number format converter
// ----------------------------------------------------------------------------
package cnfc_pkg;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_OVERFLOW    = 3'd1,
		ST_UNDERFLOW   = 3'd2,
		ST_INEXACT     = 3'd3,
		ST_NONFINITE   = 3'd4,
		ST_UNSUPPORTED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SRC_U64 = 2'd0,
		SRC_S64 = 2'd1,
		SRC_F32 = 2'd2,
		SRC_F64 = 2'd3
	} src_fmt_t;

	localparam logic [3:0] TGT_S8  = 4'd0;
	localparam logic [3:0] TGT_S16 = 4'd1;
	localparam logic [3:0] TGT_S32 = 4'd2;
	localparam logic [3:0] TGT_S64 = 4'd3;
	localparam logic [3:0] TGT_U8  = 4'd4;
	localparam logic [3:0] TGT_U16 = 4'd5;
	localparam logic [3:0] TGT_U32 = 4'd6;
	localparam logic [3:0] TGT_U64 = 4'd7;
	localparam logic [3:0] TGT_F32 = 4'd8;
	localparam logic [3:0] TGT_F64 = 4'd9;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  target_format;
		logic [63:0] source_value;
	} req_t;

	typedef struct packed {
		logic [63:0] converted_value;
		logic [2:0]  status;
	} rsp_t;

endpackage

[hw/rtl/cnfc_stream_if.sv]
// ----------------------------------------------------------------------------
// cnfc_stream_if
// valid/ready channel carrying one request or result payload
// ----------------------------------------------------------------------------
interface cnfc_stream_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/cnfc_convert.sv]
// ----------------------------------------------------------------------------
// cnfc_convert
// combinational conversion of one registered request into a result
// ----------------------------------------------------------------------------
module cnfc_convert (
	input  cnfc_pkg::req_t req,
	output cnfc_pkg::rsp_t rsp
);

	// position of highest set bit
	function automatic logic [5:0] top_bit(input logic [63:0] m);
		logic [5:0] b;
		b = '0;
		for (int i = 0; i < 64; i++) begin
			if (m[i]) begin
				b = 6'(i);
			end
		end
		return b;
	endfunction

	logic        tgt_bad, tgt_int, tgt_dbl, tgt_sgn;
	logic [6:0]  n_bits;
	logic        src_int, src_dbl;
	logic [63:0] fbits;
	logic        neg;
	logic [63:0] mag;
	logic [10:0] fexp;
	logic [51:0] ffrac;
	logic        is_nan, is_inf, is_zero;
	logic [52:0] fm;
	logic signed [12:0] e2;

	// float to integer split
	logic        huge, frac;
	logic [63:0] ip;
	logic [63:0] ipm;
	logic [6:0]  sh;

	// packing
	logic [63:0] pm;
	logic signed [12:0] pe2;
	logic signed [12:0] pe, bias, emin, q, s;
	logic [5:0]  tb;
	logic [63:0] sig, rem, half, keep;
	logic [5:0]  p;

	cnfc_pkg::status_t st_int, st_pack, st;
	logic [63:0] res_int, res_pack, res;

	always_comb begin
		tgt_bad = req.target_format > cnfc_pkg::TGT_F64;
		tgt_int = req.target_format < cnfc_pkg::TGT_F32;
		tgt_dbl = req.target_format == cnfc_pkg::TGT_F64;
		tgt_sgn = req.target_format < cnfc_pkg::TGT_U8;
		n_bits  = 7'd8 << req.target_format[1:0];
		src_int = req.opcode == cnfc_pkg::SRC_U64 || req.opcode == cnfc_pkg::SRC_S64;
		src_dbl = req.opcode == cnfc_pkg::SRC_F64;

		// float decode into m * 2^e2
		fbits = src_dbl ? req.source_value : {32'd0, req.source_value[31:0]};
		if (src_dbl) begin
			fexp  = fbits[62:52];
			ffrac = fbits[51:0];
			neg   = fbits[63];
			is_nan = fexp == 11'h7ff && ffrac != '0;
			is_inf = fexp == 11'h7ff && ffrac == '0;
		end else begin
			fexp  = {3'd0, fbits[30:23]};
			ffrac = {29'd0, fbits[22:0]};
			neg   = fbits[31];
			is_nan = fexp == 11'h0ff && ffrac != '0;
			is_inf = fexp == 11'h0ff && ffrac == '0;
		end
		is_zero = fexp == '0 && ffrac == '0;
		if (fexp == '0) begin
			fm = {1'b0, ffrac};
			e2 = src_dbl ? -13'sd1074 : -13'sd149;
		end else begin
			fm = src_dbl ? {1'b1, ffrac} : {29'd0, 1'b1, ffrac[22:0]};
			e2 = $signed({2'b0, fexp}) - (src_dbl ? 13'sd1075 : 13'sd150);
		end

		if (src_int) begin
			neg = req.opcode == cnfc_pkg::SRC_S64 && req.source_value[63];
			mag = neg ? 64'd0 - req.source_value : req.source_value;
		end else begin
			mag = {11'd0, fm};
		end

		// integer part and fraction of a float
		huge = 1'b0;
		frac = 1'b0;
		ip   = '0;
		sh   = '0;
		ipm  = '0;
		if (src_int) begin
			ip = mag;
		end else if (is_inf) begin
			huge = 1'b1;
		end else if (!is_zero) begin
			if (e2 >= 0) begin
				// significand tops out at bit 52 (double) or 23 (single)
				if ((src_dbl && e2 > 13'sd11) || (!src_dbl && e2 > 13'sd40)) begin
					huge = 1'b1;
				end else begin
					ip = mag << e2[5:0];
				end
			end else if (e2 <= -13'sd64) begin
				frac = 1'b1;
			end else begin
				sh   = 7'(-e2);
				ip   = mag >> sh[5:0];
				ipm  = ~(64'hffff_ffff_ffff_ffff << sh[5:0]);
				frac = (mag & ipm) != '0;
			end
		end

		// range then fraction check for integer targets
		res_int = '0;
		if (tgt_sgn) begin
			if (neg && (huge || ip > (64'd1 << (n_bits - 7'd1)) ||
					(ip == (64'd1 << (n_bits - 7'd1)) && frac))) begin
				st_int = cnfc_pkg::ST_UNDERFLOW;
			end else if (!neg && (huge || ip >= (64'd1 << (n_bits - 7'd1)))) begin
				st_int = cnfc_pkg::ST_OVERFLOW;
			end else if (frac) begin
				st_int = cnfc_pkg::ST_INEXACT;
			end else begin
				st_int = cnfc_pkg::ST_OK;
			end
		end else begin
			if (neg && (huge || ip != '0 || frac)) begin
				st_int = cnfc_pkg::ST_UNDERFLOW;
			end else if (huge) begin
				st_int = cnfc_pkg::ST_OVERFLOW;
			end else if (n_bits != 7'd64 && (ip >> n_bits[5:0]) != '0) begin
				st_int = cnfc_pkg::ST_OVERFLOW;
			end else if (frac) begin
				st_int = cnfc_pkg::ST_INEXACT;
			end else begin
				st_int = cnfc_pkg::ST_OK;
			end
		end
		res_int = neg ? 64'd0 - ip : ip;
		if (n_bits != 7'd64) begin
			res_int = res_int & ~(64'hffff_ffff_ffff_ffff << n_bits[5:0]);
		end
		if (!src_int && is_nan) begin
			st_int = cnfc_pkg::ST_INEXACT;
		end

		// pack into single or double with round to nearest even checks
		pm   = mag;
		pe2  = src_int ? 13'sd0 : e2;
		p    = tgt_dbl ? 6'd52 : 6'd23;
		bias = tgt_dbl ? 13'sd1023 : 13'sd127;
		emin = 13'sd1 - bias;
		tb   = top_bit(pm);
		pe   = $signed({7'd0, tb}) + pe2;
		q    = (pe >= emin) ? pe - $signed({7'd0, p}) : emin - $signed({7'd0, p});
		s    = q - pe2;
		sig  = '0;
		rem  = '0;
		half = '0;
		keep = '0;
		res_pack = '0;
		if (pe > bias) begin
			st_pack = cnfc_pkg::ST_NONFINITE;
		end else if (s >= 13'sd64) begin
			st_pack = cnfc_pkg::ST_INEXACT;
		end else begin
			st_pack = cnfc_pkg::ST_OK;
			if (s <= 0) begin
				sig = pm << 6'(-s);
			end else begin
				rem  = pm & ~(64'hffff_ffff_ffff_ffff << s[5:0]);
				keep = pm >> s[5:0];
				half = 64'd1 << 6'(s - 13'sd1);
				sig  = keep;
				if (rem != '0) begin
					st_pack = cnfc_pkg::ST_INEXACT;
					if (pe == bias && (rem > half || (rem == half && keep[0])) &&
							keep + 64'd1 == (64'd1 << (p + 6'd1))) begin
						st_pack = cnfc_pkg::ST_NONFINITE;
					end
				end
			end
			if (pe >= emin) begin
				res_pack = (64'(pe + bias) << p) | (sig & ~(64'hffff_ffff_ffff_ffff << p));
			end else begin
				res_pack = sig;
			end
			if (neg) begin
				res_pack = res_pack | (tgt_dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000);
			end
		end

		if (tgt_bad) begin
			st  = cnfc_pkg::ST_UNSUPPORTED;
			res = '0;
		end else if (tgt_int) begin
			st  = st_int;
			res = res_int;
		end else if (!src_int && (is_nan || is_inf)) begin
			st  = cnfc_pkg::ST_NONFINITE;
			res = '0;
		end else if ((src_int && mag == '0) || (!src_int && is_zero)) begin
			st  = cnfc_pkg::ST_OK;
			res = (neg && !src_int) ?
				(tgt_dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000) : 64'd0;
		end else begin
			st  = st_pack;
			res = res_pack;
		end

		rsp.status          = st;
		rsp.converted_value = (st == cnfc_pkg::ST_OK) ? res : 64'd0;
	end

endmodule

[hw/rtl/checked_number_format_convert_core.sv]
// ----------------------------------------------------------------------------
// checked_number_format_convert_core
// checked conversion between integer and ieee float formats
// ----------------------------------------------------------------------------
// usage: requests arrive on the req channel (opcode, target_format,
// source_value), results leave on the rsp channel (converted_value, status).
// each request gives exactly one result, in order.
// registers: one register holds the request, one holds the result; the result
// register loads a pending request once it is empty or its result is taken.
// throughput: one request per cycle while the receiver keeps ready high; the
// conversion logic between the two registers is a single combinational pass.
// stall: when the receiver holds ready low the result register keeps its
// value and the request register fills; req.ready falls only when both are
// full, so no result is lost or repeated.
// reset: arst_n clears both valid flags; no result is pending afterward.
// ----------------------------------------------------------------------------
`include "checked_number_format_convert_core_assert.svh"

module checked_number_format_convert_core (
	input logic clk,
	input logic arst_n,
	cnfc_stream_if.sink   req,
	cnfc_stream_if.source rsp
);

	logic           valid_s1, valid_s2;
	cnfc_pkg::req_t req_s1;
	cnfc_pkg::rsp_t rsp_s2;
	cnfc_pkg::rsp_t rsp_comb;
	logic           adv_s2, adv_s1;
	logic           rsp_zero_ok, rsp_stall;

	assign adv_s2    = valid_s1 && (!valid_s2 || rsp.ready);
	assign adv_s1    = req.valid && req.ready;
	assign req.ready = !valid_s1 || adv_s2;

	cnfc_convert u_convert (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			req_s1 <= req.data;
		end
		if (adv_s2) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

	assign rsp_zero_ok = rsp.data.status == cnfc_pkg::ST_OK ||
		rsp.data.converted_value == 64'd0;
	assign rsp_stall   = rsp.valid && !rsp.ready;

	`CNFC_ASSERT(a_zero_on_error, !rsp.valid || rsp_zero_ok, "nonzero value with error status")
	`CNFC_ASSERT_NEXT(a_stall_hold, rsp_stall, rsp.valid && $stable(rsp.data), "result moved")
	`CNFC_ASSERT_NEXT(a_s1_moves, adv_s2, valid_s2, "result register missed a request")
	`CNFC_ASSERT(a_ready_free, valid_s1 || req.ready, "ready low with empty request register")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// random and directed requests through the number format converter, each
// result checked in order against a local model of the conversion rules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [63:0]       value;
		cnfc_pkg::status_t status;
	} conv_result_t;

	logic clk;
	logic arst_n;

	cnfc_stream_if #(.payload_t(cnfc_pkg::req_t)) req (.clk(clk));
	cnfc_stream_if #(.payload_t(cnfc_pkg::rsp_t)) rsp (.clk(clk));

	checked_number_format_convert_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	cnfc_pkg::req_t pending_reqs[$];
	conv_result_t   expected_results[$];
	int             mismatch_count;
	bit             stimulus_done;
	int             burst_left;
	int             gap_left;
	int             stall_phase;
	int             hold_off_left;
	bit             hold_off_used;
	int             accepted_count;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int msb_index(logic [63:0] m);
		int b;
		b = 63;
		while (b > 0 && !m[b])
			b--;
		return b;
	endfunction

	// range and fraction check of a magnitude against an integer target
	function automatic cnfc_pkg::status_t int_range(bit neg, bit huge, logic [63:0] ip,
			bit frac, logic [3:0] tgt, output logic [63:0] res);
		int unsigned n;
		logic [63:0] lim;
		logic [63:0] v;
		n = 8 << tgt[1:0];
		res = '0;
		if (tgt < cnfc_pkg::TGT_U8) begin
			lim = 64'd1 << (n - 1);
			if (neg) begin
				if (huge || ip > lim || (ip == lim && frac))
					return cnfc_pkg::ST_UNDERFLOW;
			end else if (huge || ip >= lim) begin
				return cnfc_pkg::ST_OVERFLOW;
			end
		end else begin
			if (neg && (huge || ip != 0 || frac))
				return cnfc_pkg::ST_UNDERFLOW;
			if (huge)
				return cnfc_pkg::ST_OVERFLOW;
			if (n < 64 && ip >= (64'd1 << n))
				return cnfc_pkg::ST_OVERFLOW;
		end
		if (frac)
			return cnfc_pkg::ST_INEXACT;
		v = neg ? -ip : ip;
		if (n < 64)
			v &= (64'd1 << n) - 1;
		res = v;
		return cnfc_pkg::ST_OK;
	endfunction

	// pack nonzero m * 2^e2 into single or double
	function automatic cnfc_pkg::status_t float_pack(bit neg, logic [63:0] m, int e2,
			bit dbl, output logic [63:0] res);
		int p, bias, emin, e, q, s;
		logic [63:0] sig, rem, keep, half, bits;
		bit up;
		p = dbl ? 52 : 23;
		bias = dbl ? 1023 : 127;
		emin = 1 - bias;
		e = msb_index(m) + e2;
		res = '0;
		if (e > bias)
			return cnfc_pkg::ST_NONFINITE;
		q = (e >= emin) ? e - p : emin - p;
		s = q - e2;
		if (s <= 0) begin
			sig = m << (-s);
		end else begin
			if (s >= 64)
				return cnfc_pkg::ST_INEXACT;
			rem = m & ((64'd1 << s) - 1);
			if (rem != 0) begin
				if (e == bias) begin
					keep = m >> s;
					half = 64'd1 << (s - 1);
					up = rem > half || (rem == half && keep[0]);
					if (up && keep + 1 == (64'd1 << (p + 1)))
						return cnfc_pkg::ST_NONFINITE;
				end
				return cnfc_pkg::ST_INEXACT;
			end
			sig = m >> s;
		end
		if (e >= emin)
			bits = (64'(e + bias) << p) | (sig & ((64'd1 << p) - 1));
		else
			bits = sig;
		if (neg)
			bits[dbl ? 63 : 31] = 1'b1;
		res = bits;
		return cnfc_pkg::ST_OK;
	endfunction

	function automatic conv_result_t predict_conversion(cnfc_pkg::req_t r);
		conv_result_t out;
		logic [63:0] v, mag, m, bits, ip, res;
		logic [3:0] tgt;
		bit neg, dbl, huge, frac, is_nan, is_inf, is_zero;
		int p, ew, bias, e2;
		logic [10:0] ex;
		logic [51:0] fr;
		cnfc_pkg::status_t st;
		tgt = r.target_format;
		v = r.source_value;
		res = '0;
		if (tgt > cnfc_pkg::TGT_F64) begin
			st = cnfc_pkg::ST_UNSUPPORTED;
		end else if (r.opcode == cnfc_pkg::SRC_U64 || r.opcode == cnfc_pkg::SRC_S64) begin
			neg = (r.opcode == cnfc_pkg::SRC_S64) && v[63];
			mag = neg ? -v : v;
			if (tgt < cnfc_pkg::TGT_F32)
				st = int_range(neg, 1'b0, mag, 1'b0, tgt, res);
			else if (mag == 0)
				st = cnfc_pkg::ST_OK;
			else
				st = float_pack(neg, mag, 0, tgt == cnfc_pkg::TGT_F64, res);
		end else begin
			dbl = (r.opcode == cnfc_pkg::SRC_F64);
			bits = dbl ? v : {32'd0, v[31:0]};
			p = dbl ? 52 : 23;
			ew = dbl ? 11 : 8;
			bias = dbl ? 1023 : 127;
			ex = 11'((bits >> p) & ((64'd1 << ew) - 1));
			fr = 52'(bits & ((64'd1 << p) - 1));
			neg = bits[p + ew];
			is_nan = (ex == (1 << ew) - 1) && fr != 0;
			is_inf = (ex == (1 << ew) - 1) && fr == 0;
			is_zero = ex == 0 && fr == 0;
			m = 0;
			e2 = 0;
			if (ex == 0) begin
				m = 64'(fr);
				e2 = 1 - bias - p;
			end else begin
				m = 64'(fr) | (64'd1 << p);
				e2 = int'(ex) - bias - p;
			end
			if (tgt < cnfc_pkg::TGT_F32) begin
				if (is_nan) begin
					st = cnfc_pkg::ST_INEXACT;
				end else if (is_inf) begin
					st = int_range(neg, 1'b1, 0, 1'b0, tgt, res);
				end else if (is_zero) begin
					st = int_range(neg, 1'b0, 0, 1'b0, tgt, res);
				end else begin
					huge = 0;
					frac = 0;
					ip = 0;
					if (e2 >= 0) begin
						if (e2 >= 64 || (e2 > 0 && (m >> (64 - e2)) != 0))
							huge = 1;
						else
							ip = m << e2;
					end else if (e2 <= -64) begin
						frac = 1;
					end else begin
						ip = m >> (-e2);
						frac = (m & ((64'd1 << (-e2)) - 1)) != 0;
					end
					st = int_range(neg, huge, ip, frac, tgt, res);
				end
			end else if (is_nan || is_inf) begin
				st = cnfc_pkg::ST_NONFINITE;
			end else if (is_zero) begin
				st = cnfc_pkg::ST_OK;
				if (neg)
					res = 64'd1 << ((tgt == cnfc_pkg::TGT_F64) ? 63 : 31);
			end else begin
				st = float_pack(neg, m, e2, tgt == cnfc_pkg::TGT_F64, res);
			end
		end
		out.value = (st == cnfc_pkg::ST_OK) ? res : 64'd0;
		out.status = st;
		return out;
	endfunction

	function automatic logic [63:0] random_value(logic [1:0] op);
		logic [63:0] v;
		logic [63:0] ex;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = 64'($signed(v[15:0]));
			1: v = v >> $urandom_range(0, 63);
			2: begin
				// float in a useful exponent band
				if (op == cnfc_pkg::SRC_F32) begin
					ex = 64'($urandom_range(100, 200));
					v[30:23] = ex[7:0];
				end else begin
					ex = 64'($urandom_range(950, 1110));
					v[62:52] = ex[10:0];
				end
			end
			3: begin
				// few significand bits so conversions can be exact
				if (op == cnfc_pkg::SRC_F32)
					v[22:0] = v[22:0] & 23'h7f0000;
				else
					v[51:0] = v[51:0] & 52'hff000_0000_0000;
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic add_req(logic [1:0] op, logic [3:0] tgt, logic [63:0] v);
		cnfc_pkg::req_t r;
		r.opcode = op;
		r.target_format = tgt;
		r.source_value = v;
		pending_reqs.push_back(r);
	endtask

	initial begin
		cnfc_pkg::req_t r;
		arst_n = 1'b0;
		stimulus_done = 1'b0;
		add_req(cnfc_pkg::SRC_U64, cnfc_pkg::TGT_S8, 64'd127);
		add_req(cnfc_pkg::SRC_U64, cnfc_pkg::TGT_S8, 64'd128);
		add_req(cnfc_pkg::SRC_S64, cnfc_pkg::TGT_S8, -64'sd128);
		add_req(cnfc_pkg::SRC_S64, cnfc_pkg::TGT_S8, -64'sd129);
		add_req(cnfc_pkg::SRC_U64, cnfc_pkg::TGT_U64, 64'hffff_ffff_ffff_ffff);
		add_req(cnfc_pkg::SRC_S64, cnfc_pkg::TGT_S64, 64'h8000_0000_0000_0000);
		add_req(cnfc_pkg::SRC_S64, cnfc_pkg::TGT_F64, 64'h8000_0000_0000_0000);
		add_req(cnfc_pkg::SRC_U64, cnfc_pkg::TGT_F32, 64'h0000_0000_0100_0001);
		add_req(cnfc_pkg::SRC_U64, 4'd10, 64'd5);
		add_req(cnfc_pkg::SRC_U64, 4'd15, 64'd0);
		add_req(cnfc_pkg::SRC_F32, cnfc_pkg::TGT_U8, 64'hffff_ffff_bf00_0000);
		add_req(cnfc_pkg::SRC_F32, cnfc_pkg::TGT_U8, 64'h0000_0000_8000_0000);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_S16, 64'h7ff0_0000_0000_0000);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_S16, 64'hfff0_0000_0000_0000);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_S32, 64'h7ff8_0000_0000_0001);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_S32, 64'h3ff8_0000_0000_0000);
		add_req(cnfc_pkg::SRC_F32, cnfc_pkg::TGT_F64, 64'h0000_0000_7fc0_0000);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_F32, 64'h47ef_ffff_f000_0000);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_F32, 64'h0000_0000_0000_0001);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_F64, 64'h8000_0000_0000_0000);
		add_req(cnfc_pkg::SRC_F32, cnfc_pkg::TGT_F32, 64'h1234_5678_8000_0001);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_U64, 64'h43f0_0000_0000_0000);
		add_req(cnfc_pkg::SRC_F64, cnfc_pkg::TGT_S64, 64'hc3e0_0000_0000_0000);
		// single values with large exponents into wide integers
		add_req(cnfc_pkg::SRC_F32, cnfc_pkg::TGT_S64, 64'h0000_0000_5380_0001);
		add_req(cnfc_pkg::SRC_F32, cnfc_pkg::TGT_U64, 64'h0000_0000_5f7f_ffff);
		add_req(cnfc_pkg::SRC_F32, cnfc_pkg::TGT_S64, 64'h0000_0000_df00_0000);
		for (int i = 0; i < 1700; i++) begin
			r.opcode = 2'($urandom_range(0, 3));
			r.target_format = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			r.source_value = random_value(r.opcode);
			pending_reqs.push_back(r);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0);
		stimulus_done = 1'b1;
	end

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(predict_conversion(req.data));
				void'(pending_reqs.pop_front());
				accepted_count <= accepted_count + 1;
			end
			if (!req.valid || req.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req.valid <= 1'b0;
				end else if (pending_reqs.size() > ((req.valid && req.ready) ? 0 : 1) - 1
						&& pending_reqs.size() != 0) begin
					req.valid <= 1'b1;
					req.data <= pending_reqs[0];
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: own stall pattern plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_phase <= 0;
			hold_off_left <= 0;
			hold_off_used <= 1'b0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (!hold_off_used && accepted_count > 600) begin
				hold_off_used <= 1'b1;
				hold_off_left <= 60;
				rsp.ready <= 1'b0;
			end else if (hold_off_left > 0) begin
				hold_off_left <= hold_off_left - 1;
				rsp.ready <= 1'b0;
			end else if (stall_phase[9:8] == 2'd3) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		conv_result_t exp_res;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result value=%h status=%0d",
						rsp.data.converted_value, rsp.data.status);
			end else begin
				exp_res = expected_results.pop_front();
				if (rsp.data.converted_value !== exp_res.value
						|| rsp.data.status !== exp_res.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp value=%h status=%0d, got value=%h status=%0d",
							exp_res.value, exp_res.status,
							rsp.data.converted_value, rsp.data.status);
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		accepted_count = 0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		wait (stimulus_done);
		wait (expected_results.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#200000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
